### design/lms_pkg.sv
// shared constants and codes of the lms adaptive fir filter
package lms_pkg;

   // filter size and weight format
   localparam int TAP_COUNT = 1024;
   localparam int W_FRAC    = 40;
   localparam int TAP_BITS  = $clog2(TAP_COUNT);
   localparam int VHC_W     = TAP_BITS + 1;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int W_W      = 48;
   localparam int OUT_W    = 18;
   localparam int DIFF_W   = OUT_W + 1;
   localparam int SUM_W    = W_W + 1;
   localparam int IDX_W    = 10;
   localparam int SHIFT_W  = 6;
   localparam int TAPS_W   = 11;
   localparam int CNT_W    = (VHC_W > TAPS_W) ? VHC_W : TAPS_W;
   localparam int PROD_W   = W_W + SAMPLE_W;
   localparam int ACC_W    = PROD_W + TAP_BITS;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UPDATE_SHIFT = 1'b0,
      CSR_TAPS_IN_USE  = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   localparam logic [SHIFT_W-1:0] UPDATE_SHIFT_RESET = 6'd2;
   localparam logic [TAPS_W-1:0]  TAPS_IN_USE_RESET  = 11'd1024;

   // rounding and saturation bounds
   localparam logic signed [ACC_W-1:0] ACC_ROUND_HALF =
      {{(ACC_W - W_FRAC){1'b0}}, 1'b1, {(W_FRAC - 1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};
   localparam logic signed [W_W-1:0]   W_MAX   = {1'b0, {(W_W - 1){1'b1}}};
   localparam logic signed [W_W-1:0]   W_MIN   = {1'b1, {(W_W - 1){1'b0}}};

endpackage

### design/lms_adaptive_fir.sv
// lms adaptive fir filter with one shared multiplier under a small sequencer
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | kind, input_sample, target_sample,
//          |           |                       | restart, tap_index
//  rsp     | out       | rsp_valid / rsp_ready | filter_output, error_value, tap_weight
//  csr     | in        | csr_valid / csr_ready | index, data (always ready)
//
// a sample item runs a multiply-accumulate pass over the n taps taking part
// (at most 1024) and a weight update pass, each with its read and multiply
// stages, both through the single multiplier at one tap per cycle and one weight
// port. a read item goes from its read state to the final state. after reset a
// clearing pass writes zero to all TAP_COUNT weights with req_ready low; csr
// writes are taken. a result waits in the output register; the next item is taken
// meanwhile and only its final load waits for rsp_ready.
module lms_adaptive_fir (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample and read items
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic signed [lms_pkg::SAMPLE_W-1:0]   req_input_sample,
   input  logic signed [lms_pkg::SAMPLE_W-1:0]   req_target_sample,
   input  logic                                  req_restart,
   input  logic [lms_pkg::IDX_W-1:0]             req_tap_index,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [lms_pkg::OUT_W-1:0]      rsp_filter_output,
   output logic signed [lms_pkg::OUT_W-1:0]      rsp_error_value,
   output logic signed [lms_pkg::W_W-1:0]        rsp_tap_weight,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lms_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lms_pkg::CSR_DATA_W-1:0]        csr_data
);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_MAC   = 8'b0000_0100,
      ST_ROUND = 8'b0000_1000,
      ST_ERR   = 8'b0001_0000,
      ST_UPD   = 8'b0010_0000,
      ST_RD    = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // control state
   logic [lms_pkg::TAP_BITS-1:0] clr_ff, clr_in;
   logic [lms_pkg::TAP_BITS-1:0] wp_ff, wp_in;
   logic [lms_pkg::VHC_W-1:0]    vhc_ff, vhc_in;
   logic [lms_pkg::SHIFT_W-1:0]  shift_ff, shift_in;
   logic [lms_pkg::TAPS_W-1:0]   taps_ff, taps_in;
   logic                         s1_ff, s1_in;
   logic                         s2_ff, s2_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // pass counters and payload
   logic [lms_pkg::VHC_W-1:0]         n_ff, n_in;
   logic [lms_pkg::VHC_W-1:0]         j_ff, j_in;
   logic [lms_pkg::TAP_BITS-1:0]      p_ff, p_in;
   logic [lms_pkg::TAP_BITS-1:0]      a1_ff, a1_in;
   logic [lms_pkg::TAP_BITS-1:0]      a2_ff, a2_in;
   logic signed [lms_pkg::W_W-1:0]    w2_ff, w2_in;
   logic signed [lms_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [lms_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic signed [lms_pkg::OUT_W-1:0]  y_ff, y_in;
   logic signed [lms_pkg::OUT_W-1:0]  e_ff, e_in;
   logic signed [lms_pkg::SAMPLE_W-1:0] target_ff, target_in;
   logic                              kind_ff, kind_in;
   logic [lms_pkg::TAP_BITS-1:0]      idx_ff, idx_in;
   logic                              idx_ok_ff, idx_ok_in;
   logic signed [lms_pkg::OUT_W-1:0]  rsp_fo_ff, rsp_fo_in;
   logic signed [lms_pkg::OUT_W-1:0]  rsp_err_ff, rsp_err_in;
   logic signed [lms_pkg::W_W-1:0]    rsp_tw_ff, rsp_tw_in;

   // memories
   logic signed [lms_pkg::W_W-1:0]      weights [lms_pkg::TAP_COUNT];
   logic signed [lms_pkg::SAMPLE_W-1:0] history [lms_pkg::TAP_COUNT];
   logic signed [lms_pkg::W_W-1:0]      w_rd_ff;
   logic signed [lms_pkg::SAMPLE_W-1:0] h_rd_ff;
   logic                                w_we, w_re, h_we, h_re;
   logic [lms_pkg::TAP_BITS-1:0]        w_wa, w_ra;
   logic signed [lms_pkg::W_W-1:0]      w_wd;

   // datapath
   logic                                issue;
   logic                                in_pass;
   logic signed [lms_pkg::W_W-1:0]      mul_a;
   logic signed [lms_pkg::PROD_W-1:0]   mul_p;
   logic signed [lms_pkg::ACC_W-1:0]    acc_rnd, acc_sh;
   logic signed [lms_pkg::OUT_W-1:0]    y_round;
   logic signed [lms_pkg::DIFF_W-1:0]   diff;
   logic signed [lms_pkg::OUT_W-1:0]    e_sat;
   logic signed [lms_pkg::PROD_W-1:0]   upd_d;
   logic signed [lms_pkg::SUM_W-1:0]    upd_sum;
   logic signed [lms_pkg::W_W-1:0]      w_new;
   logic [lms_pkg::VHC_W-1:0]           vhc_next, n_next;
   logic [lms_pkg::CNT_W-1:0]           taps_lim;

   assign req_ready         = (state_ff == ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filter_output = rsp_fo_ff;
   assign rsp_error_value   = rsp_err_ff;
   assign rsp_tap_weight    = rsp_tw_ff;

   // shared multiplier: weight times sample, then error times sample
   assign mul_a = (state_ff == ST_UPD) ? lms_pkg::W_W'(e_ff) : w_rd_ff;
   assign mul_p = mul_a * h_rd_ff;

   // round accumulator half up and saturate to output width
   always_comb begin
      acc_rnd = acc_ff + lms_pkg::ACC_ROUND_HALF;
      acc_sh  = acc_rnd >>> lms_pkg::W_FRAC;
      if (acc_sh > lms_pkg::ACC_W'(lms_pkg::OUT_MAX)) begin
         y_round = lms_pkg::OUT_MAX;
      end else if (acc_sh < lms_pkg::ACC_W'(lms_pkg::OUT_MIN)) begin
         y_round = lms_pkg::OUT_MIN;
      end else begin
         y_round = acc_sh[lms_pkg::OUT_W-1:0];
      end
   end

   // error with saturation
   always_comb begin
      diff = lms_pkg::DIFF_W'(target_ff) - lms_pkg::DIFF_W'(y_ff);
      if (diff > lms_pkg::DIFF_W'(lms_pkg::OUT_MAX)) begin
         e_sat = lms_pkg::OUT_MAX;
      end else if (diff < lms_pkg::DIFF_W'(lms_pkg::OUT_MIN)) begin
         e_sat = lms_pkg::OUT_MIN;
      end else begin
         e_sat = diff[lms_pkg::OUT_W-1:0];
      end
   end

   // weight update: floor shift of the product, add, saturate
   always_comb begin
      upd_d   = prod_ff >>> shift_ff;
      upd_sum = lms_pkg::SUM_W'(w2_ff) + lms_pkg::SUM_W'(upd_d);
      if (upd_sum > lms_pkg::SUM_W'(lms_pkg::W_MAX)) begin
         w_new = lms_pkg::W_MAX;
      end else if (upd_sum < lms_pkg::SUM_W'(lms_pkg::W_MIN)) begin
         w_new = lms_pkg::W_MIN;
      end else begin
         w_new = upd_sum[lms_pkg::W_W-1:0];
      end
   end

   // history fill and number of taps for a new sample item
   always_comb begin
      if (req_restart) begin
         vhc_next = lms_pkg::VHC_W'(1);
      end else if (vhc_ff == lms_pkg::VHC_W'(lms_pkg::TAP_COUNT)) begin
         vhc_next = vhc_ff;
      end else begin
         vhc_next = vhc_ff + 1'b1;
      end
      if (lms_pkg::CNT_W'(taps_ff) > lms_pkg::CNT_W'(lms_pkg::TAP_COUNT)) begin
         taps_lim = lms_pkg::CNT_W'(lms_pkg::TAP_COUNT);
      end else begin
         taps_lim = lms_pkg::CNT_W'(taps_ff);
      end
      if (lms_pkg::CNT_W'(vhc_next) < taps_lim) begin
         n_next = vhc_next;
      end else begin
         n_next = lms_pkg::VHC_W'(taps_lim);
      end
   end

   // sequencer and next values
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      wp_in        = wp_ff;
      vhc_in       = vhc_ff;
      shift_in     = shift_ff;
      taps_in      = taps_ff;
      s1_in        = 1'b0;
      s2_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      n_in         = n_ff;
      j_in         = j_ff;
      p_in         = p_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      w2_in        = w2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      target_in    = target_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      rsp_fo_in    = rsp_fo_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_tw_in    = rsp_tw_ff;
      w_we         = 1'b0;
      w_wa         = a2_ff;
      w_wd         = w_new;
      w_re         = 1'b0;
      w_ra         = j_ff[lms_pkg::TAP_BITS-1:0];
      h_we         = 1'b0;
      h_re         = 1'b0;

      // tap pipeline shared by both passes: read, multiply, use
      in_pass = (state_ff == ST_MAC) || (state_ff == ST_UPD);
      issue   = in_pass && (j_ff != n_ff);
      if (issue) begin
         w_re = 1'b1;
         h_re = 1'b1;
         j_in = j_ff + 1'b1;
         if (p_ff == '0) begin
            p_in = lms_pkg::TAP_BITS'(lms_pkg::TAP_COUNT - 1);
         end else begin
            p_in = p_ff - 1'b1;
         end
      end
      if (in_pass) begin
         s1_in = issue;
         s2_in = s1_ff;
         a1_in = j_ff[lms_pkg::TAP_BITS-1:0];
         a2_in = a1_ff;
         w2_in = w_rd_ff;
         if (s1_ff) begin
            prod_in = mul_p;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            w_we   = 1'b1;
            w_wa   = clr_ff;
            w_wd   = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == lms_pkg::TAP_BITS'(lms_pkg::TAP_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               target_in = req_target_sample;
               if (req_kind == lms_pkg::KIND_READ) begin
                  idx_in    = lms_pkg::TAP_BITS'(req_tap_index);
                  idx_ok_in = int'(req_tap_index) < lms_pkg::TAP_COUNT;
                  state_in  = ST_RD;
               end else begin
                  h_we     = 1'b1;
                  vhc_in   = vhc_next;
                  n_in     = n_next;
                  acc_in   = '0;
                  j_in     = '0;
                  p_in     = wp_ff;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            if (s2_ff) begin
               acc_in = acc_ff + lms_pkg::ACC_W'(prod_ff);
            end
            if (!issue && !s1_ff && !s2_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            y_in     = y_round;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            e_in     = e_sat;
            j_in     = '0;
            p_in     = wp_ff;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (s2_ff) begin
               w_we = 1'b1;
            end
            if (!issue && !s1_ff && !s2_ff) begin
               if (wp_ff == lms_pkg::TAP_BITS'(lms_pkg::TAP_COUNT - 1)) begin
                  wp_in = '0;
               end else begin
                  wp_in = wp_ff + 1'b1;
               end
               state_in = ST_FIN;
            end
         end
         ST_RD: begin
            w_re     = 1'b1;
            w_ra     = idx_ff;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               if (kind_ff == lms_pkg::KIND_READ) begin
                  rsp_fo_in  = '0;
                  rsp_err_in = '0;
                  rsp_tw_in  = idx_ok_ff ? w_rd_ff : '0;
               end else begin
                  rsp_fo_in  = y_ff;
                  rsp_err_in = e_ff;
                  rsp_tw_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes
      if (csr_valid) begin
         unique case (csr_index)
            lms_pkg::CSR_UPDATE_SHIFT: shift_in = csr_data[lms_pkg::SHIFT_W-1:0];
            lms_pkg::CSR_TAPS_IN_USE:  taps_in  = csr_data[lms_pkg::TAPS_W-1:0];
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         wp_ff        <= '0;
         vhc_ff       <= '0;
         shift_ff     <= lms_pkg::UPDATE_SHIFT_RESET;
         taps_ff      <= lms_pkg::TAPS_IN_USE_RESET;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wp_ff        <= wp_in;
         vhc_ff       <= vhc_in;
         shift_ff     <= shift_in;
         taps_ff      <= taps_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      j_ff       <= j_in;
      p_ff       <= p_in;
      a1_ff      <= a1_in;
      a2_ff      <= a2_in;
      w2_ff      <= w2_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      y_ff       <= y_in;
      e_ff       <= e_in;
      target_ff  <= target_in;
      kind_ff    <= kind_in;
      idx_ff     <= idx_in;
      idx_ok_ff  <= idx_ok_in;
      rsp_fo_ff  <= rsp_fo_in;
      rsp_err_ff <= rsp_err_in;
      rsp_tw_ff  <= rsp_tw_in;
   end

   // weight memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (w_we) begin
         weights[w_wa] <= w_wd;
      end
      if (w_re) begin
         w_rd_ff <= weights[w_ra];
      end
   end

   // sample delay line memory
   always_ff @(posedge clock) begin
      if (h_we) begin
         history[wp_ff] <= req_input_sample;
      end
      if (h_re) begin
         h_rd_ff <= history[p_ff];
      end
   end

endmodule

### design/lms_checker.sv
// port-level checks of the lms adaptive fir filter and their bind
module lms_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [lms_pkg::OUT_W-1:0]      rsp_filter_output,
   input logic signed [lms_pkg::OUT_W-1:0]      rsp_error_value,
   input logic signed [lms_pkg::W_W-1:0]        rsp_tap_weight
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_filter_output) && $stable(rsp_error_value)
         && $stable(rsp_tap_weight))
      else $error("stalled result changed");

   // busy the cycle after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // clearing pass after reset, no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or result right after reset");

   // a weight result carries no filter output or error
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tap_weight != '0) |->
         (rsp_filter_output == '0) && (rsp_error_value == '0))
      else $error("mixed result fields");

endmodule

bind lms_adaptive_fir lms_checker u_lms_checker (.*);
